/* src/osmc_pkg.sv */
package osmc_pkg;

    localparam int MAX_PATTERN    = 32;
    localparam int PAT_IDX_BITS   = $clog2(MAX_PATTERN);
    localparam int LEN_BITS       = 6;
    localparam int COORD_BITS     = 16;
    localparam int COUNT_BITS     = 24;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PAT_REG_BYTES  = CFG_DATA_BITS / 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PAT_0_7   = 3'd0,
        REG_PAT_8_15  = 3'd1,
        REG_PAT_16_23 = 3'd2,
        REG_PAT_24_31 = 3'd3,
        REG_PAT_LEN   = 3'd4,
        REG_CUR_COL   = 3'd5,
        REG_CUR_LINE  = 3'd6,
        REG_TARGET    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       line_end;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] match_total;
        logic [COUNT_BITS-1:0] active_match;
        logic                  target_found;
        logic [COORD_BITS-1:0] target_col;
        logic [COORD_BITS-1:0] target_line;
    } out_item_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // one item after the matching stage
    typedef struct packed {
        logic                  hit;
        logic [COORD_BITS-1:0] start;
        logic [COORD_BITS-1:0] line;
        logic                  text_end;
    } match_evt_t;

endpackage

/* src/osmc_cell.sv */
module osmc_cell
    import osmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic [7:0] text_byte,
    input  logic [7:0] pat_byte,
    input  logic      prefix_in,
    output logic      match_now,
    output logic      prefix_out
);

    logic flag_reg;
    logic flag_next;

    // prefix up to this cell matches, ending at the incoming byte
    assign match_now  = prefix_in && (text_byte == pat_byte);
    assign prefix_out = flag_reg;

    always_comb
    begin
        flag_next = flag_reg;
        if (ctl.clear)
        begin
            flag_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            flag_next = match_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

endmodule

/* src/osmc_tally.sv */
module osmc_tally
    import osmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  match_evt_t            evt,
    input  logic [COORD_BITS-1:0] cursor_col,
    input  logic [COORD_BITS-1:0] cursor_line,
    input  logic [COUNT_BITS-1:0] target_match,
    output out_item_t             result
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] count_reg, count_next, count_upd, count_inc;
    logic                  seen_reg, seen_next, seen_upd;
    logic [COUNT_BITS-1:0] index_reg, index_next, index_upd;
    logic                  thit_reg, thit_next, thit_upd;
    logic [COORD_BITS-1:0] tcol_reg, tcol_next, tcol_upd;
    logic [COORD_BITS-1:0] tline_reg, tline_next, tline_upd;
    logic                  hit_ok, cur_take, tgt_take;

    always_comb
    begin
        count_inc = count_reg + COUNT_BITS'(1);
        // a saturated count takes no further matches
        hit_ok    = evt.hit && (count_reg != COUNT_MAX);
        cur_take  = hit_ok && !seen_reg &&
                    ((evt.line > cursor_line) ||
                     ((evt.line == cursor_line) && (evt.start >= cursor_col)));
        tgt_take  = hit_ok && !thit_reg && (target_match != '0) &&
                    (count_inc == target_match);

        count_upd = hit_ok   ? count_inc : count_reg;
        seen_upd  = seen_reg || cur_take;
        index_upd = cur_take ? count_inc : index_reg;
        thit_upd  = thit_reg || tgt_take;
        tcol_upd  = tgt_take ? evt.start : tcol_reg;
        tline_upd = tgt_take ? evt.line  : tline_reg;

        result.match_total  = count_upd;
        result.active_match = seen_upd ? index_upd :
                              ((count_upd != '0) ? COUNT_BITS'(1) : '0);
        result.target_found = thit_upd;
        result.target_col   = thit_upd ? tcol_upd  : '0;
        result.target_line  = thit_upd ? tline_upd : '0;

        count_next = count_reg;
        seen_next  = seen_reg;
        index_next = index_reg;
        thit_next  = thit_reg;
        tcol_next  = tcol_reg;
        tline_next = tline_reg;
        if (step)
        begin
            if (evt.text_end)
            begin
                count_next = '0;
                seen_next  = 1'b0;
                index_next = '0;
                thit_next  = 1'b0;
                tcol_next  = '0;
                tline_next = '0;
            end
            else
            begin
                count_next = count_upd;
                seen_next  = seen_upd;
                index_next = index_upd;
                thit_next  = thit_upd;
                tcol_next  = tcol_upd;
                tline_next = tline_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
            index_reg <= '0;
            thit_reg  <= 1'b0;
            tcol_reg  <= '0;
            tline_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            seen_reg  <= seen_next;
            index_reg <= index_next;
            thit_reg  <= thit_next;
            tcol_reg  <= tcol_next;
            tline_reg <= tline_next;
        end
    end

    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && evt.text_end |=> count_reg == '0 && !seen_reg && !thit_reg)
        else $error("tally not cleared after text end");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> index_reg != '0 && index_reg <= count_reg)
        else $error("current match index outside count");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(step && evt.text_end) |-> count_reg >= $past(count_reg))
        else $error("match count went backwards");

endmodule

/* src/overlapping_substring_match_counter.sv */
// A text-end item is registered in the tally stage; its result is then registered into the
// output slot once that slot is free.
// Throughput: one item per cycle; the cell row shifts on every accepted byte and the tally
// stage takes each item from the event register. Input stalls only while a result waits
// at the output. Reset (rst_n, async, active low) clears configuration, cell flags, counters
// and the output valid flag; the block is ready for items as soon as reset is released.
module overlapping_substring_match_counter
    import osmc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_item_t                 out_data
);

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    // configuration
    logic [MAX_PATTERN-1:0][7:0] pattern_reg;
    logic [LEN_BITS-1:0]         pattern_len_reg;
    logic [COORD_BITS-1:0]       cursor_col_reg;
    logic [COORD_BITS-1:0]       cursor_line_reg;
    logic [COUNT_BITS-1:0]       target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            pattern_len_reg <= '0;
            cursor_col_reg  <= '0;
            cursor_line_reg <= '0;
            target_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PAT_0_7:   pattern_reg[0*PAT_REG_BYTES +: PAT_REG_BYTES] <= cfg_data;
                REG_PAT_8_15:  pattern_reg[1*PAT_REG_BYTES +: PAT_REG_BYTES] <= cfg_data;
                REG_PAT_16_23: pattern_reg[2*PAT_REG_BYTES +: PAT_REG_BYTES] <= cfg_data;
                REG_PAT_24_31: pattern_reg[3*PAT_REG_BYTES +: PAT_REG_BYTES] <= cfg_data;
                REG_PAT_LEN:   pattern_len_reg <= cfg_data[LEN_BITS-1:0];
                REG_CUR_COL:   cursor_col_reg  <= cfg_data[COORD_BITS-1:0];
                REG_CUR_LINE:  cursor_line_reg <= cfg_data[COORD_BITS-1:0];
                REG_TARGET:    target_reg      <= cfg_data[COUNT_BITS-1:0];
            endcase
        end
    end

    // lengths above the row are clamped to the full row
    logic [LEN_BITS-1:0]     eff_len;
    logic [PAT_IDX_BITS-1:0] tap_sel;

    assign eff_len = (pattern_len_reg > LEN_BITS'(MAX_PATTERN)) ?
                     LEN_BITS'(MAX_PATTERN) : pattern_len_reg;
    assign tap_sel = PAT_IDX_BITS'(eff_len - LEN_BITS'(1));

    // handshake and pipeline advance
    logic       in_xfer;
    logic       evt_valid_reg, evt_valid_next;
    match_evt_t evt_reg, evt_next;
    logic       evt_go;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg;
    out_item_t  tally_result;

    // the tally stage only needs the output slot for a text-end transfer
    assign evt_go   = evt_valid_reg && (!evt_reg.text_end || !out_valid_reg || out_ready);
    assign in_ready = !evt_valid_reg || evt_go;
    assign in_xfer  = in_valid && in_ready;

    // cell row: cell k flags "pattern bytes 0..k match, ending at the latest byte"
    cell_ctl_t              cell_ctl;
    logic [MAX_PATTERN-1:0] match_now;
    logic [MAX_PATTERN-1:0] prefix;

    assign cell_ctl.shift = in_xfer && in_data.has_char;
    assign cell_ctl.clear = in_xfer && (in_data.line_end || in_data.text_end);

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic prefix_in;
        if (k == 0)
        begin : g_head
            assign prefix_in = 1'b1;
        end
        else
        begin : g_body
            assign prefix_in = prefix[k-1];
        end

        osmc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl),
            .text_byte  (in_data.ch),
            .pat_byte   (pattern_reg[k]),
            .prefix_in  (prefix_in),
            .match_now  (match_now[k]),
            .prefix_out (prefix[k])
        );
    end

    // column and line of the byte being taken
    logic [COORD_BITS-1:0] column_reg, column_next;
    logic [COORD_BITS-1:0] line_reg, line_next;

    always_comb
    begin
        column_next = column_reg;
        line_next   = line_reg;
        if (in_xfer)
        begin
            if (in_data.has_char && (column_reg != COORD_MAX))
            begin
                column_next = column_reg + COORD_BITS'(1);
            end
            if (in_data.text_end)
            begin
                column_next = '0;
                line_next   = '0;
            end
            else if (in_data.line_end)
            begin
                column_next = '0;
                if (line_reg != COORD_MAX)
                begin
                    line_next = line_reg + COORD_BITS'(1);
                end
            end
        end

        evt_next.hit      = in_data.has_char && (eff_len != '0) && match_now[tap_sel];
        // a match ending in a saturated column reports the saturated column as its start
        evt_next.start    = (column_reg != COORD_MAX) ?
                            column_reg + COORD_BITS'(1) - COORD_BITS'(eff_len) : COORD_MAX;
        evt_next.line     = line_reg;
        evt_next.text_end = in_data.text_end;

        evt_valid_next = evt_valid_reg;
        if (in_xfer)
        begin
            evt_valid_next = 1'b1;
        end
        else if (evt_go)
        begin
            evt_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (evt_go && evt_reg.text_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            line_reg      <= '0;
            evt_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg    <= column_next;
            line_reg      <= line_next;
            evt_valid_reg <= evt_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            evt_reg <= evt_next;
        end
        if (evt_go && evt_reg.text_end)
        begin
            out_reg <= tally_result;
        end
    end

    osmc_tally u_tally (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (evt_go),
        .evt          (evt_reg),
        .cursor_col   (cursor_col_reg),
        .cursor_line  (cursor_line_reg),
        .target_match (target_reg),
        .result       (tally_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_data.text_end |=> column_reg == '0 && line_reg == '0)
        else $error("coordinates not cleared after text end");

    a_cells_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_data.line_end || in_data.text_end) |=> prefix == '0)
        else $error("cell flags survive a line end");

    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid_reg && !evt_go |=> evt_valid_reg && $stable(evt_reg))
        else $error("stalled tally entry lost or changed");

    a_no_hit_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_data.has_char && (eff_len != '0) && match_now[tap_sel] |->
        column_reg + COORD_BITS'(1) >= COORD_BITS'(eff_len) || column_reg == COORD_MAX)
        else $error("match reported before enough bytes in the line");

endmodule
